// ===== hdl/ssc_pkg.sv =====
// shared types and constants for the stack sequence checker
// no dependencies; imported by the stack ram and the core

package ssc_pkg;

    localparam int VALUE_W  = 11;
    // push value counter is one bit wider so it can pass the widest wanted value
    localparam int NPV_W    = VALUE_W + 1;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_PUSH_POP = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POP_TOP  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic               start_sequence;
        logic [VALUE_W-1:0] wanted_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  push_count;
        logic [VALUE_W-1:0]  first_pushed;
        logic [STATUS_W-1:0] status;
        logic                sequence_failed;
    } t_out_item;

endpackage

// ===== hdl/stack_sequence_checker_core.sv =====
// stack sequence checker: push/pop sequencer around the stack ram
// depends on ssc_pkg and ssc_stack_ram
//
// Usage:
//   input channel  i_in_valid / o_in_ready carries t_in_item (start flag and
//   the value the next pop must deliver); output channel o_out_valid /
//   i_out_ready carries one t_out_item per input transfer, in order.
//   Throughput and ram use, by kind of input item:
//   - out of range, already failed, push-then-pop with no earlier values to
//     push, or a pop from an empty stack: one item per cycle while the
//     receiver keeps taking results
//   - push run that stores k values below the wanted one: one ram write per
//     cycle, then the result; no new item is taken during the run
//   - pop of an earlier pushed value: one ram read, then a compare; no new item is taken before it
//   The single ram port allows one write or one read per cycle.
//   A finished result sits in an output register; the next item is taken
//   while it waits. The block stalls during a push run or a pop, and when a
//   second result is ready before the receiver takes the first.
//   Reset: stack empty, next push value 1, failure flag clear. Stack ram
//   contents are not cleared; only written entries are ever compared.

module stack_sequence_checker_core
    import ssc_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int DW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int unsigned LIM = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam logic [VALUE_W-1:0] W_MAX = VALUE_W'(LIM);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PUSH = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [DW-1:0]      r_depth, n_depth;
    logic [NPV_W-1:0]   r_npv, n_npv;
    logic               r_failed, n_failed;
    logic               r_pend, n_pend;
    logic               r_ov, n_ov;
    logic [VALUE_W-1:0] r_want, n_want;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;

    logic               acc;
    logic               out_free;
    logic               start;
    logic [VALUE_W-1:0] want;
    logic [NPV_W-1:0]   want_x;
    logic [DW-1:0]      e_depth;
    logic [NPV_W-1:0]   e_npv;
    logic               e_failed;
    logic [DW-1:0]      top_idx;

    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [VALUE_W-1:0] mem_rdata;

    ssc_stack_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign out_free   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && (!r_pend || out_free);
    assign acc        = i_in_valid && o_in_ready;

    assign start    = i_in_data.start_sequence;
    assign want     = i_in_data.wanted_value;
    assign want_x   = {1'b0, want};
    assign e_depth  = start ? '0 : r_depth;
    assign e_npv    = start ? NPV_W'(1) : r_npv;
    assign e_failed = start ? 1'b0 : r_failed;
    assign top_idx  = e_depth - DW'(1);

    // ram port: writes during a push run, otherwise read at the stack top
    assign mem_we    = (r_state == S_PUSH);
    assign mem_addr  = (r_state == S_PUSH) ? r_depth[AW-1:0] : top_idx[AW-1:0];
    assign mem_wdata = r_npv[VALUE_W-1:0];

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        n_npv    = r_npv;
        n_failed = r_failed;
        n_pend   = r_pend;
        n_ov     = r_ov;
        n_want   = r_want;
        n_res    = r_res;
        n_out    = r_out;

        // output register: take the pending result or drain on transfer
        if (r_pend && out_free) begin
            n_out  = r_res;
            n_ov   = 1'b1;
            n_pend = 1'b0;
        end else if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_depth  = e_depth;
                    n_npv    = e_npv;
                    n_failed = e_failed;
                    n_want   = want;
                    n_res.push_count      = '0;
                    n_res.first_pushed    = e_npv[VALUE_W-1:0];
                    n_res.sequence_failed = e_failed;
                    if (want == '0 || want > W_MAX) begin
                        n_res.status = ST_RANGE;
                        n_pend       = 1'b1;
                    end else if (e_failed) begin
                        n_res.status = ST_FAILED;
                        n_pend       = 1'b1;
                    end else if (want_x >= e_npv) begin
                        n_res.status     = ST_PUSH_POP;
                        n_res.push_count = want - e_npv[VALUE_W-1:0] + VALUE_W'(1);
                        if (want_x == e_npv) begin
                            // wanted value is pushed and popped at once
                            n_npv  = want_x + NPV_W'(1);
                            n_pend = 1'b1;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end else if (e_depth == '0) begin
                        n_res.status          = ST_MISMATCH;
                        n_res.sequence_failed = 1'b1;
                        n_failed              = 1'b1;
                        n_pend                = 1'b1;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_PUSH: begin
                n_depth = r_depth + DW'(1);
                if (r_npv + NPV_W'(1) == {1'b0, r_want}) begin
                    // last value below the wanted one stored; wanted one popped
                    n_npv   = {1'b0, r_want} + NPV_W'(1);
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_npv = r_npv + NPV_W'(1);
                end
            end
            S_CMP: begin
                if (mem_rdata == r_want) begin
                    n_depth      = r_depth - DW'(1);
                    n_res.status = ST_POP_TOP;
                end else begin
                    n_failed              = 1'b1;
                    n_res.status          = ST_MISMATCH;
                    n_res.sequence_failed = 1'b1;
                end
                n_pend  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_npv    <= NPV_W'(1);
            r_failed <= 1'b0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_npv    <= n_npv;
            r_failed <= n_failed;
            r_pend   <= n_pend;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want <= n_want;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

// ===== hdl/ssc_stack_ram.sv =====
// single port stack storage, one write or one registered read per cycle
// depends on ssc_pkg for the entry width

module ssc_stack_ram
    import ssc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_addr,
    input  logic [VALUE_W-1:0] i_wdata,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/ssc_sequence_monitor.sv =====
// channel monitor for the stack sequence checker: predicts each pop result and compares
// depends on ssc_pkg; instantiated by tb_stack_sequence_checker_core

module ssc_sequence_monitor
    import ssc_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic [VALUE_W-1:0] stack_vals [DEPTH];
    int                 stack_level = 0;
    int                 next_value  = 1;
    bit                 seq_failed  = 1'b0;
    t_out_item          expected_pops [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_out_item predict_pop(input t_in_item item);
        t_out_item res;
        int        want;
        int        pushes;
        pushes = 0;
        want   = int'(item.wanted_value);
        if (item.start_sequence) begin
            stack_level = 0;
            next_value  = 1;
            seq_failed  = 1'b0;
        end
        res.first_pushed = next_value[VALUE_W-1:0];
        if (want == 0 || want > DEPTH) begin
            res.status = ST_RANGE;
        end else if (seq_failed) begin
            res.status = ST_FAILED;
        end else if (want >= next_value) begin
            // push every value up to the wanted one, then pop it straight away
            while (next_value <= want && stack_level < DEPTH) begin
                stack_vals[stack_level] = next_value[VALUE_W-1:0];
                stack_level++;
                next_value++;
                pushes++;
            end
            if (stack_level > 0)
                stack_level--;
            res.status = ST_PUSH_POP;
        end else if (stack_level > 0 && stack_vals[stack_level-1] == item.wanted_value) begin
            stack_level--;
            res.status = ST_POP_TOP;
        end else begin
            seq_failed = 1'b1;
            res.status = ST_MISMATCH;
        end
        res.push_count      = pushes[VALUE_W-1:0];
        res.sequence_failed = seq_failed;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        if (o_fail_count < 10)
            $display("%s", msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item exp_res;
        if (!i_rst_n) begin
            stack_level = 0;
            next_value  = 1;
            seq_failed  = 1'b0;
            expected_pops.delete();
        end else begin
            // a result can never come from the input transfer of the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_pops.size() == 0) begin
                    note_failure($sformatf("unexpected result cnt=%0d first=%0d st=%0d fail=%0d",
                        i_out_data.push_count, i_out_data.first_pushed,
                        i_out_data.status, i_out_data.sequence_failed));
                end else begin
                    exp_res = expected_pops.pop_front();
                    if (exp_res.push_count !== i_out_data.push_count ||
                        exp_res.first_pushed !== i_out_data.first_pushed ||
                        exp_res.status !== i_out_data.status ||
                        exp_res.sequence_failed !== i_out_data.sequence_failed) begin
                        note_failure({
                            $sformatf("mismatch exp cnt=%0d first=%0d st=%0d fail=%0d",
                                exp_res.push_count, exp_res.first_pushed,
                                exp_res.status, exp_res.sequence_failed),
                            $sformatf(", got cnt=%0d first=%0d st=%0d fail=%0d",
                                i_out_data.push_count, i_out_data.first_pushed,
                                i_out_data.status, i_out_data.sequence_failed)});
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_pops.push_back(predict_pop(i_in_data));
        end
        o_pending = expected_pops.size();
    end

endmodule

// ===== tb/tb_stack_sequence_checker_core.sv =====
// testbench top for the stack sequence checker: clock, reset, stimulus and verdict
// depends on ssc_pkg, stack_sequence_checker_core and ssc_sequence_monitor

module tb_stack_sequence_checker_core;
    import ssc_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int PHASE_ITEMS = 170;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int items_sent     = 0;

    int send_pct_tbl [5] = '{0, 84, 0, 38, 0};
    int recv_pct_tbl [5] = '{0, 0, 84, 38, 0};

    t_in_item stim_items [$];

    always #6 i_clk = ~i_clk;

    stack_sequence_checker_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    ssc_sequence_monitor #(
        .DEPTH(DEPTH)
    ) i_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_item(input bit start, input int value);
        t_in_item item;
        item.start_sequence = start;
        item.wanted_value   = value[VALUE_W-1:0];
        stim_items.push_back(item);
    endtask

    // valid stays high across back-to-back transfers unless an idle cycle is drawn
    task automatic offer_item(input t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_queued();
        while (stim_items.size() > 0)
            offer_item(stim_items.pop_front());
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // a realizable pop order of 1..n, optionally corrupted in one place
    task automatic build_sequence(input int n, input bit broken);
        int held [$];
        int vals [$];
        int push_next;
        int j;
        int tmp;
        bit lead_start;
        push_next  = 1;
        lead_start = ($urandom_range(9) != 0);
        while (vals.size() < n) begin
            if (held.size() == 0 || (push_next <= n && $urandom_range(1) == 1)) begin
                held.push_back(push_next);
                push_next++;
            end else begin
                vals.push_back(held.pop_back());
            end
        end
        if (broken) begin
            j = $urandom_range(n - 1);
            if (j + 1 < n && $urandom_range(1) == 1) begin
                tmp         = vals[j];
                vals[j]     = vals[j + 1];
                vals[j + 1] = tmp;
            end else begin
                vals[j] = $urandom_range(1, n);
            end
        end
        foreach (vals[k])
            queue_item(k == 0 ? lead_start : 1'b0, vals[k]);
    endtask

    task automatic build_noise();
        int count;
        count = $urandom_range(1, 4);
        repeat (count) begin
            if ($urandom_range(1) == 1)
                queue_item($urandom_range(3) == 0, $urandom_range(2047));
            else
                queue_item($urandom_range(3) == 0, $urandom_range(0, 40));
        end
    endtask

    initial begin : stimulus
        int pick;
        int n;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: range limits, pops from top, empty-stack and buried mismatches
        queue_item(1'b1, 1);
        queue_item(1'b0, 0);
        queue_item(1'b0, 1025);
        queue_item(1'b0, 2047);
        queue_item(1'b1, 3);
        queue_item(1'b0, 2);
        queue_item(1'b0, 1);
        queue_item(1'b0, 1);
        queue_item(1'b0, 5);
        queue_item(1'b0, 0);
        queue_item(1'b1, 1024);
        queue_item(1'b0, 1023);
        queue_item(1'b0, 1021);
        queue_item(1'b1, 0);
        queue_item(1'b0, 1);
        queue_item(1'b0, 3);
        queue_item(1'b0, 1);
        queue_item(1'b1, 2);
        queue_item(1'b0, 1);
        queue_item(1'b0, 3);
        send_queued();
        wait_drained();

        items_sent = 0;
        for (int p = 0; p < 5; p++) begin
            send_idle_pct  = send_pct_tbl[p];
            recv_stall_pct = recv_pct_tbl[p];
            if (p == 4)
                hold_requests++;
            while (items_sent < (p + 1) * PHASE_ITEMS) begin
                pick = $urandom_range(99);
                n    = ($urandom_range(24) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 20);
                if (pick < 70)
                    build_sequence(n, 1'b0);
                else if (pick < 85)
                    build_sequence(n, 1'b1);
                else
                    build_noise();
                send_queued();
            end
            // sender pauses until every result is back
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
